// ----- rtl/fba_pkg.sv -----
// fba_pkg: shared types and constants for the fit block allocator
// holds table sizing, mode codes, register indexes and the scan record type
// no dependencies
package fba_pkg;

   localparam int BLOCKS    = 16;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS  = 4;
   localparam int CNT_BITS  = 5;

   // placement policy codes; the unused code behaves as first fit
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // register indexes on the csr port
   localparam logic REG_FIT_MODE      = 1'b0;
   localparam logic REG_BLOCKS_IN_USE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // search record handed from cell to cell
   typedef struct packed {
      logic                 found;
      logic [SIZE_BITS-1:0] pick;
      logic [IDX_BITS-1:0]  pos;
   } srch_type;

endpackage

// ----- rtl/fba_cell.sv -----
// fba_cell: one table entry plus one stage of the search chain
// depends on fba_pkg
module fba_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fba_pkg::IDX_BITS-1:0]  cell_idx_i,
   input  logic [fba_pkg::CNT_BITS-1:0]  count_i,
   input  logic [1:0]                    mode_i,
   input  logic [fba_pkg::SIZE_BITS-1:0] size_i,
   input  logic                          wr_en_i,
   input  logic [fba_pkg::SIZE_BITS-1:0] wr_data_i,
   input  fba_pkg::srch_type             srch_i,
   output fba_pkg::srch_type             srch_o
);
   import fba_pkg::*;

   logic [SIZE_BITS-1:0] entry_ff;
   srch_type             srch_ff;
   srch_type             srch_in;
   logic                 active;
   logic                 fits;
   logic                 take;

   assign active = {1'b0, cell_idx_i} < count_i;
   assign fits   = entry_ff >= size_i;

   always_comb begin
      unique case (mode_i)
         FIT_WORST: take = active && (!srch_i.found || entry_ff > srch_i.pick);
         FIT_BEST:  take = active && fits && (!srch_i.found || entry_ff < srch_i.pick);
         default:   take = active && fits && !srch_i.found;
      endcase
      srch_in = srch_i;
      if (take) begin
         srch_in.found = 1'b1;
         srch_in.pick  = entry_ff;
         srch_in.pos   = cell_idx_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (wr_en_i) begin
         entry_ff <= wr_data_i;
      end
   end

   always_ff @(posedge clock) begin
      srch_ff <= srch_in;
   end

   assign srch_o = srch_ff;

endmodule

// ----- rtl/fit_block_allocator_core.sv -----
// fit_block_allocator_core: table of block sizes with first, best and worst fit placement
// builds a row of fba_cell stages, a small sequencer and the csr registers
// depends on fba_pkg and fba_cell
//
// Each table entry lives in its own cell; an allocate word sends a search record down
// the row of cells, one cell per cycle, and each cell may claim the record for its
// entry. An allocate word passes through the scan over the 16-cell row and then the
// commit step; a load word goes straight to the commit step. A new word is taken only
// after the last one has left the commit step. A finished result sits in an output
// register, so it may wait for rsp_tready while the next word is taken in; a second
// finished word waits in the commit step and holds off the input. Config registers:
// fit_mode at 0x0 (0 first, 1 best, 2 worst, 3 as first), blocks_in_use at 0x4
// (values above 16 count as 16). After reset all entries read zero.
module fit_block_allocator_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] block_index, [19:4] size_value, rest zero
   input  logic        req_tuser,   // [0] opcode
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] chosen_block, [19:4] remaining_size, rest zero
   output logic        rsp_tuser,   // [0] granted
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fba_pkg::*;

   // config registers
   logic [1:0]          fit_mode_ff;
   logic [CNT_BITS-1:0] blocks_ff;
   logic                csr_wr;

   // sequencer and captured word
   state_type            state_ff, state_in;
   logic [IDX_BITS-1:0]  scan_cnt_ff, scan_cnt_in;
   logic                 op_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic                 req_fire;
   logic                 commit;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_grant_ff;
   logic [IDX_BITS-1:0]  rsp_block_ff;
   logic [SIZE_BITS-1:0] rsp_rem_ff;

   // cell row
   srch_type             link [BLOCKS+1];
   srch_type             tail;
   logic [CNT_BITS-1:0]  count_sat;
   logic [BLOCKS-1:0]    wr_en;
   logic [SIZE_BITS-1:0] wr_data;
   logic                 alloc_ok;
   logic                 load_ok;
   logic                 grant;
   logic [IDX_BITS-1:0]  grant_block;
   logic [SIZE_BITS-1:0] grant_rem;

   // csr access, always ready
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_FIRST;
         blocks_ff   <= CNT_BITS'(BLOCKS);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_FIT_MODE:      fit_mode_ff <= csr_pwdata[1:0];
            REG_BLOCKS_IN_USE: blocks_ff   <= csr_pwdata[CNT_BITS-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FIT_MODE:      csr_prdata = {30'd0, fit_mode_ff};
         REG_BLOCKS_IN_USE: csr_prdata = {{(32-CNT_BITS){1'b0}}, blocks_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // entries searched, saturated to the table size
   assign count_sat = (blocks_ff > CNT_BITS'(BLOCKS)) ? CNT_BITS'(BLOCKS) : blocks_ff;

   // the row start always injects an empty record
   assign link[0] = '0;

   for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
      fba_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx_i (IDX_BITS'(i)),
         .count_i    (count_sat),
         .mode_i     (fit_mode_ff),
         .size_i     (size_ff),
         .wr_en_i    (wr_en[i]),
         .wr_data_i  (wr_data),
         .srch_i     (link[i]),
         .srch_o     (link[i+1])
      );
   end

   assign tail = link[BLOCKS];

   // worst fit only grants if the largest entry fits
   assign alloc_ok = tail.found && !(fit_mode_ff == FIT_WORST && tail.pick < size_ff);
   assign load_ok  = {1'b0, idx_ff} < (IDX_BITS+1)'(BLOCKS);

   always_comb begin
      if (op_ff == OP_LOAD) begin
         grant       = load_ok;
         grant_block = load_ok ? idx_ff : '0;
         grant_rem   = load_ok ? size_ff : '0;
      end else begin
         grant       = alloc_ok;
         grant_block = alloc_ok ? tail.pos : '0;
         grant_rem   = alloc_ok ? (tail.pick - size_ff) : '0;
      end
   end

   assign wr_data = grant_rem;

   always_comb begin
      for (int i = 0; i < BLOCKS; i++) begin
         wr_en[i] = commit && grant && (grant_block == IDX_BITS'(i));
      end
   end

   // sequencer
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      commit       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (req_fire) begin
               state_in = (req_tuser == OP_ALLOC) ? ST_SCAN : ST_UPDATE;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == IDX_BITS'(BLOCKS-1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait for room in the output register
            if (!rsp_valid_ff || rsp_tready) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // captured word, held for the whole scan
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_tuser;
         idx_ff  <= req_tdata[IDX_BITS-1:0];
         size_ff <= req_tdata[IDX_BITS +: SIZE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_grant_ff <= grant;
         rsp_block_ff <= grant_block;
         rsp_rem_ff   <= grant_rem;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_grant_ff;
   assign rsp_tdata  = {{(24-IDX_BITS-SIZE_BITS){1'b0}}, rsp_rem_ff, rsp_block_ff};

   // an accepted word always leads into the scan or the commit step
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN || state_ff == ST_UPDATE))
      else $error("accepted word did not start processing");

   // the scan covers the whole cell row before commit
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && $past(state_ff) == ST_SCAN)
         |-> $past(scan_cnt_ff) == IDX_BITS'(BLOCKS-1))
      else $error("scan left the cell row early");

   // a refused word reports zero block and zero size
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_grant_ff) |-> (rsp_block_ff == '0 && rsp_rem_ff == '0))
      else $error("refused result carries nonzero fields");

   // a commit never overwrites a result still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overrun");

endmodule
